// ===== rtl/ptul_pkg.sv =====
`timescale 1ns / 1ps

package ptul_pkg;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_UPSERT = 1'b1;

    localparam int KEY_W   = 64;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    localparam int ENTRY_W = ADDR_W + PORT_W + TIME_W;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] seen;
    } ptul_entry_t;

    typedef struct packed {
        logic               hit;
        logic               dropped;
        logic [SLOT_W-1:0]  slot;
        ptul_entry_t        entry;
        logic [COUNT_W-1:0] count;
    } ptul_result_t;

endpackage

// ===== rtl/peer_table_upsert_lookup.sv =====
`timescale 1ns / 1ps

// Peer table with find and upsert requests keyed by a 128-bit identifier.
// Each request item enters on the s_ channel (s_valid/s_ready) and yields
// exactly one result item on the m_ channel (m_valid/m_ready).
// Keys sit in one memory and address, port and last-seen time in another,
// both with a registered read port. A request scans the filled slots from
// slot 0 upward, one key read per cycle, and stops at the first match.
// The result is loaded into the output register as the resolve step
// completes, and s_ready rises again in that same cycle, so the next
// item may be accepted while the result still waits for m_ready.
// Items are otherwise accepted one at a time, as s_ready stays low
// while a request scans the table or waits in its resolve step.
// If the receiver stalls, the finished request waits in its resolve step
// and its table write happens only once the output register frees up.
// Reset empties the table by clearing the filled count; no memory sweep.

module peer_table_upsert_lookup #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [ptul_pkg::KEY_W-1:0]  s_key_high,
    input  logic [ptul_pkg::KEY_W-1:0]  s_key_low,
    input  logic [ptul_pkg::ADDR_W-1:0] s_peer_address,
    input  logic [ptul_pkg::PORT_W-1:0] s_peer_port,
    input  logic [ptul_pkg::TIME_W-1:0] s_now_time,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic                         m_dropped,
    output logic [ptul_pkg::SLOT_W-1:0]  m_slot,
    output logic [ptul_pkg::ADDR_W-1:0]  m_entry_address,
    output logic [ptul_pkg::PORT_W-1:0]  m_entry_port,
    output logic [ptul_pkg::TIME_W-1:0]  m_entry_seen,
    output logic [ptul_pkg::COUNT_W-1:0] m_entry_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEYS_W = 2 * ptul_pkg::KEY_W;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0] state_reg, state_next;

    logic                        op_reg;
    logic [KEYS_W-1:0]           key_reg;
    ptul_pkg::ptul_entry_t       req_entry_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] match_reg, match_next;

    logic                  m_valid_reg;
    ptul_pkg::ptul_result_t result_reg, result_next;

    logic              key_rd_en, key_wr_en;
    logic [IDX_W-1:0]  key_rd_addr;
    logic [KEYS_W-1:0] key_rd_data;
    logic              data_rd_en, data_wr_en;
    logic [IDX_W-1:0]  data_rd_addr;
    logic [ptul_pkg::ENTRY_W-1:0] data_rd_data;

    logic              accept, out_free, key_match, scan_end;
    logic [CNT_W-1:0]  scan_inc;
    logic              is_upsert, full, do_write, resolve_fire, append;
    logic [IDX_W-1:0]  wr_slot;
    logic [IDX_W+ptul_pkg::SLOT_W-1:0]  slot_wide;
    logic [CNT_W+ptul_pkg::COUNT_W-1:0] count_wide;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign key_match = (key_rd_data == key_reg);
    assign scan_inc  = scan_reg + CNT_W'(1);
    assign scan_end  = (scan_inc == count_reg);

    assign is_upsert    = (op_reg == ptul_pkg::OP_UPSERT);
    assign full         = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_write     = is_upsert && (hit_reg || !full);
    assign append       = do_write && !hit_reg;
    assign resolve_fire = (state_reg == ST_RESOLVE) && out_free;
    assign wr_slot      = hit_reg ? match_reg : count_reg[IDX_W-1:0];

    assign key_wr_en  = resolve_fire && append;
    assign data_wr_en = resolve_fire && do_write;

    always_comb begin
        key_rd_en    = 1'b0;
        key_rd_addr  = '0;
        data_rd_en   = 1'b0;
        data_rd_addr = scan_reg[IDX_W-1:0];
        state_next   = state_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_next = '0;
                    hit_next  = 1'b0;
                    if (count_reg != '0) begin
                        key_rd_en  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESOLVE;
                    end
                end
            end
            ST_SCAN: begin
                if (key_match) begin
                    data_rd_en = 1'b1;
                    hit_next   = 1'b1;
                    match_next = scan_reg[IDX_W-1:0];
                    state_next = ST_RESOLVE;
                end else if (scan_end) begin
                    state_next = ST_RESOLVE;
                end else begin
                    key_rd_en   = 1'b1;
                    key_rd_addr = scan_inc[IDX_W-1:0];
                    scan_next   = scan_inc;
                end
            end
            ST_RESOLVE: begin
                if (out_free) begin
                    if (append) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot_wide  = {{ptul_pkg::SLOT_W{1'b0}}, wr_slot};
    assign count_wide = {{ptul_pkg::COUNT_W{1'b0}}, count_next};

    always_comb begin
        result_next         = '0;
        result_next.hit     = hit_reg;
        result_next.dropped = is_upsert && !hit_reg && full;
        result_next.count   = count_wide[ptul_pkg::COUNT_W-1:0];
        if (do_write) begin
            result_next.slot  = slot_wide[ptul_pkg::SLOT_W-1:0];
            result_next.entry = req_entry_reg;
        end else if (hit_reg) begin
            result_next.slot  = slot_wide[ptul_pkg::SLOT_W-1:0];
            result_next.entry = ptul_pkg::ptul_entry_t'(data_rd_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (resolve_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg  <= scan_next;
        hit_reg   <= hit_next;
        match_reg <= match_next;
        if (accept) begin
            op_reg                <= s_operation;
            key_reg               <= {s_key_high, s_key_low};
            req_entry_reg.address <= s_peer_address;
            req_entry_reg.port    <= s_peer_port;
            req_entry_reg.seen    <= s_now_time;
        end
        if (resolve_fire) begin
            result_reg <= result_next;
        end
    end

    ptul_ram #(
        .WIDTH (KEYS_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (wr_slot),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    ptul_ram #(
        .WIDTH (ptul_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (data_wr_en),
        .wr_addr (wr_slot),
        .wr_data (req_entry_reg),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd_data)
    );

    assign m_valid         = m_valid_reg;
    assign m_hit           = result_reg.hit;
    assign m_dropped       = result_reg.dropped;
    assign m_slot          = result_reg.slot;
    assign m_entry_address = result_reg.entry.address;
    assign m_entry_port    = result_reg.entry.port;
    assign m_entry_seen    = result_reg.entry.seen;
    assign m_entry_count   = result_reg.count;

endmodule

// ===== rtl/ptul_ram.sv =====
`timescale 1ns / 1ps

module ptul_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
